>>> rtl/sfcd_pkg.sv
// Package for the status frame CRC decoder: word types, frame constants
// and the CRC-8 byte update function.
// Depends on nothing; every other file of the block uses it.
package sfcd_pkg;

  // CRC-8 with polynomial x^8 + x^2 + x + 1, no reflection, no final XOR.
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [7:0] CrcTopBit = 8'h80;
  localparam logic [7:0] LowNibble = 8'h0F;
  localparam logic [0:0] OneBit    = 1'b1;

  // Frame layout: seven captured bytes followed by the CRC byte.
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosWidth   = $clog2(FrameBytes);
  localparam int unsigned DataBytes  = FrameBytes - 1;
  localparam logic [PosWidth-1:0] FrameLast = PosWidth'(DataBytes);

  typedef logic [PosWidth-1:0] frame_pos_t;

  // One incoming frame byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } frame_word_t;

  // One decoded frame.
  typedef struct packed {
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [7:0]  value_integer;
    logic [3:0]  value_tenths;
    logic        power_plugged;
    logic [15:0] sender_calls;
    logic [7:0]  sent_crc;
    logic        crc_valid;
  } result_word_t;

  // Folds one byte into the running CRC, one bit of the byte per step.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTopBit) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/sfcd_if.sv
// Valid/ready channel interfaces for the status frame CRC decoder.
// Depends on sfcd_pkg for the word types.

// Channel carrying frame bytes into the decoder.
interface sfcd_frame_if;
  logic                      valid;
  logic                      ready;
  sfcd_pkg::frame_word_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Channel carrying decoded frames out of the decoder.
interface sfcd_result_if;
  logic                      valid;
  logic                      ready;
  sfcd_pkg::result_word_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/status_frame_crc_decoder.sv
// Top level of the status frame CRC decoder.
// Depends on sfcd_pkg and on the channel interfaces in sfcd_if.sv.

// The decoder takes one frame byte per clock cycle unless held off and emits
// one decoded word per eight-byte frame, registered, in the cycle after the
// final byte is taken. Each data byte goes through a single CRC-8 update and
// the position counter when accepted; the last byte is checked against the
// CRC, so the sustained rate is one byte per cycle. The result register
// decouples the two sides: bytes keep flowing while a decoded word waits, and
// input is held off only when a word is still waiting in the result register
// and is not being taken. A byte marked as frame start always begins a new
// frame and drops any partial one; after the eighth byte the next byte starts
// a new frame anyway. The first eight bytes after reset form a frame.
module status_frame_crc_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfcd_frame_if.sink            frame_i,
  sfcd_result_if.source         result_o
);

  // Frame state.
  sfcd_pkg::frame_pos_t pos_q, pos_d;
  logic [7:0]           crc_q, crc_d;
  logic [7:0]           captured_q [sfcd_pkg::DataBytes];

  // Result register.
  logic                   out_valid_q, out_valid_d;
  sfcd_pkg::result_word_t out_data_q;
  sfcd_pkg::result_word_t result_w;

  logic                 accept_w;
  logic                 is_last_w;
  sfcd_pkg::frame_pos_t pos_w;
  logic [7:0]           crc_w;

  // A byte is taken unless a decoded word is stuck in the result register.
  assign frame_i.ready = !out_valid_q || result_o.ready;
  assign accept_w      = frame_i.valid && frame_i.ready;

  // Frame start overrides the running position and CRC.
  assign pos_w     = frame_i.data.frame_start ? '0 : pos_q;
  assign crc_w     = frame_i.data.frame_start ? 8'h00 : crc_q;
  assign is_last_w = (pos_w == sfcd_pkg::FrameLast);

  // Decode of the finished frame from the captured bytes and the CRC byte.
  always_comb begin
    result_w.hour          = captured_q[0];
    result_w.minute        = captured_q[1];
    result_w.second        = captured_q[2];
    result_w.value_integer = captured_q[3];
    result_w.value_tenths  = 4'(captured_q[4] & sfcd_pkg::LowNibble);
    result_w.power_plugged = captured_q[4][4] & sfcd_pkg::OneBit;
    result_w.sender_calls  = {captured_q[5], captured_q[6]};
    result_w.sent_crc      = frame_i.data.data_byte;
    result_w.crc_valid     = (crc_w == frame_i.data.data_byte);
  end

  // Next position, CRC and result-valid.
  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept_w) begin
      if (is_last_w) begin
        pos_d       = '0;
        crc_d       = 8'h00;
        out_valid_d = 1'b1;
      end else begin
        pos_d = pos_w + sfcd_pkg::PosWidth'(1);
        crc_d = sfcd_pkg::crc8_fold(crc_w, frame_i.data.data_byte);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured bytes and result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      if (is_last_w) begin
        out_data_q <= result_w;
      end else begin
        captured_q[pos_w] <= frame_i.data.data_byte;
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // The final byte of a frame always produces a decoded word next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && is_last_w |=> out_valid_q && pos_q == '0 && crc_q == 8'h00)
    else $error("final frame byte did not produce a result or clear state");

  // A decoded word appears only after the final byte of a frame.
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept_w && is_last_w))
    else $error("result appeared without a completed frame");

  // Input is held off while a waiting word is not taken.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !frame_i.ready)
    else $error("byte accepted while a result was stalled");

  // Position and CRC do not move without an accepted byte.
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_w |=> $stable(pos_q) && $stable(crc_q))
    else $error("frame state changed without an accepted byte");

endmodule
